// ===== sv/raf_pkg.sv =====
package raf_pkg;

    localparam int MATERIALS = 16;
    localparam int MAT_W     = (MATERIALS > 1) ? $clog2(MATERIALS) : 1;
    localparam int IDX_W     = 4;

    localparam logic [1:0] ACT_COMPUTE  = 2'd0;
    localparam logic [1:0] ACT_LOAD_EA  = 2'd1;
    localparam logic [1:0] ACT_LOAD_SA  = 2'd2;
    localparam logic [1:0] ACT_LOAD_K   = 2'd3;

    localparam int IN_W  = 2 + IDX_W + 32 * 9;
    localparam int IN_TW = ((IN_W + 7) / 8) * 8;
    localparam int OUT_TW = 128;

    typedef logic signed [31:0] t_s32;

    typedef struct packed {
        t_s32 ex, ey, ez, gx, gy, gz, k;
    } t_mat;

    // saturate a wide signed value to 32 bits
    function automatic t_s32 sat32(input logic signed [95:0] x);
        if (x > 96'sd2147483647)
            return 32'sh7fffffff;
        else if (x < -96'sd2147483648)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

    // a*b >>> n (floor), saturated
    function automatic t_s32 mul_sat(input t_s32 a, input t_s32 b, input int n);
        logic signed [63:0] p;
        p = a * b;
        return sat32(96'(p >>> n));
    endfunction

endpackage

// ===== sv/raf_table.sv =====
module raf_table import raf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_we,
    input  logic [1:0]       i_act,
    input  logic [IDX_W-1:0] i_wmat,
    input  t_s32             i_a0,
    input  t_s32             i_a1,
    input  t_s32             i_a2,
    input  logic [IDX_W-1:0] i_rmat,
    output t_mat             o_mat
);
    t_mat r_tab [MATERIALS];
    logic [MATERIALS-1:0] r_ea_v, r_sa_v, r_k_v;
    logic wvalid, rvalid;
    logic [MAT_W-1:0] wi, ri;
    t_mat r_mat;

    assign wvalid = 32'(i_wmat) < MATERIALS;
    assign rvalid = 32'(i_rmat) < MATERIALS;
    assign wi = MAT_W'(i_wmat);
    assign ri = MAT_W'(i_rmat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ea_v <= '0;
            r_sa_v <= '0;
            r_k_v  <= '0;
        end else if (i_we && wvalid) begin
            case (i_act)
                ACT_LOAD_EA: r_ea_v[wi] <= 1'b1;
                ACT_LOAD_SA: r_sa_v[wi] <= 1'b1;
                ACT_LOAD_K:  r_k_v[wi]  <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && wvalid) begin
            case (i_act)
                ACT_LOAD_EA: begin
                    r_tab[wi].ex <= i_a0; r_tab[wi].ey <= i_a1; r_tab[wi].ez <= i_a2;
                end
                ACT_LOAD_SA: begin
                    r_tab[wi].gx <= i_a0; r_tab[wi].gy <= i_a1; r_tab[wi].gz <= i_a2;
                end
                ACT_LOAD_K: r_tab[wi].k <= i_a0;
                default: ;
            endcase
        end
    end

    // invalid entries read as zero
    always_ff @(posedge i_clk) begin
        r_mat.ex <= (rvalid && r_ea_v[ri]) ? r_tab[ri].ex : '0;
        r_mat.ey <= (rvalid && r_ea_v[ri]) ? r_tab[ri].ey : '0;
        r_mat.ez <= (rvalid && r_ea_v[ri]) ? r_tab[ri].ez : '0;
        r_mat.gx <= (rvalid && r_sa_v[ri]) ? r_tab[ri].gx : '0;
        r_mat.gy <= (rvalid && r_sa_v[ri]) ? r_tab[ri].gy : '0;
        r_mat.gz <= (rvalid && r_sa_v[ri]) ? r_tab[ri].gz : '0;
        r_mat.k  <= (rvalid && r_k_v[ri])  ? r_tab[ri].k  : '0;
    end

    assign o_mat = r_mat;
endmodule

// ===== sv/raf_core.sv =====
module raf_core import raf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  logic  i_act_on,
    input  t_mat  i_mat,
    input  t_s32  i_sx, i_sy, i_sz,
    input  t_s32  i_fx, i_fy, i_fz,
    input  logic  i_last,
    output logic  o_valid,
    output logic [OUT_TW:0] o_data
);
    localparam int NS = 10;
    logic [NS-1:0] r_v;
    logic r_on [NS];
    logic r_last [NS];
    t_s32 r_fx [NS], r_fy [NS], r_fz [NS];
    t_mat r_m [NS];

    // stage 1: projection products
    logic signed [63:0] r_pz [3], r_py [3];
    t_s32 r_szq, r_syq, r_z2, r_y2, r_zz, r_yy, r_yz;
    t_s32 r_sz3, r_sy3, r_syz3, r_sz4, r_sy4, r_syz4;
    logic signed [63:0] r_z4, r_y4;
    t_s32 r_y2z2, r_z2d, r_y2d;
    logic signed [63:0] r_polyy, r_polyz, r_polye;
    t_s32 r_qy, r_qz, r_qe, r_sz5, r_sy5, r_syz5;
    t_s32 r_u, r_w, r_e;
    t_s32 r_yc, r_zc, r_en;
    logic signed [63:0] r_t [6];
    t_s32 r_en9;
    t_s32 r_ox, r_oy, r_oz, r_oe;
    logic r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else          r_v <= {r_v[NS-2:0], i_valid};
    end

    always_ff @(posedge i_clk) begin
        r_on[0] <= i_act_on & i_en; r_last[0] <= i_last;
        r_fx[0] <= i_fx; r_fy[0] <= i_fy; r_fz[0] <= i_fz; r_m[0] <= i_mat;
        for (int i = 1; i < NS; i++) begin
            r_on[i] <= r_on[i-1]; r_last[i] <= r_last[i-1];
            r_fx[i] <= r_fx[i-1]; r_fy[i] <= r_fy[i-1]; r_fz[i] <= r_fz[i-1];
            r_m[i] <= r_m[i-1];
        end
        // s0
        r_pz[0] <= i_sx * i_mat.ex; r_pz[1] <= i_sy * i_mat.ey; r_pz[2] <= i_sz * i_mat.ez;
        r_py[0] <= i_sx * i_mat.gx; r_py[1] <= i_sy * i_mat.gy; r_py[2] <= i_sz * i_mat.gz;
        // s1
        r_szq <= sat32(96'(r_pz[0] >>> 30) + 96'(r_pz[1] >>> 30) + 96'(r_pz[2] >>> 30));
        r_syq <= sat32(96'(r_py[0] >>> 30) + 96'(r_py[1] >>> 30) + 96'(r_py[2] >>> 30));
        // s2
        r_z2 <= mul_sat(r_szq, r_szq, 30);
        r_y2 <= mul_sat(r_syq, r_syq, 30);
        r_yz <= mul_sat(r_syq, r_szq, 30);
        r_zz <= r_szq; r_yy <= r_syq;
        // s3
        r_z4 <= (r_z2 * r_z2) >>> 30;
        r_y4 <= (r_y2 * r_y2) >>> 30;
        r_y2z2 <= mul_sat(r_y2, r_z2, 30);
        r_z2d <= r_z2; r_y2d <= r_y2;
        r_sz3 <= r_zz; r_sy3 <= r_yy; r_syz3 <= r_yz;
        // s4: polynomials in Q.30
        r_polyy <= 16*r_y4 + 12*64'(r_y2z2) + r_z4
                   - 2*(6*64'(r_y2d) + 64'(r_z2d)) + 5*(64'sd1 <<< 30);
        r_polyz <= 16*r_y4 + 60*64'(r_y2z2) + 25*r_z4
                   - 10*(2*64'(r_y2d) + 3*64'(r_z2d)) + 5*(64'sd1 <<< 30);
        r_polye <= 16*r_y4 + 20*64'(r_y2z2) + 5*r_z4
                   - 10*(2*64'(r_y2d) + 64'(r_z2d)) + 5*(64'sd1 <<< 30);
        r_sz4 <= r_sz3; r_sy4 <= r_sy3; r_syz4 <= r_syz3;
        // s5
        r_qy <= sat32(96'(r_polyy >>> 14));
        r_qz <= sat32(96'(r_polyz >>> 14));
        r_qe <= sat32(96'(r_polye >>> 14));
        r_sz5 <= r_sz4; r_sy5 <= r_sy4; r_syz5 <= r_syz4;
        // s6
        r_u <= sat32(96'(5) * 96'(mul_sat(r_sz5, r_qy, 30)));
        r_w <= mul_sat(r_sy5, r_qz, 30);
        r_e <= mul_sat(r_syz5, r_qe, 30);
        // s7
        r_yc <= mul_sat(r_m[6].k, r_u, 16);
        r_zc <= mul_sat(r_m[6].k, r_w, 16);
        r_en <= sat32(-(96'((64'(r_m[6].k) * 64'(r_e)) >>> 16)));
        // s8
        r_t[0] <= (r_zc * r_m[7].ex) >>> 30; r_t[1] <= (r_yc * r_m[7].gx) >>> 30;
        r_t[2] <= (r_zc * r_m[7].ey) >>> 30; r_t[3] <= (r_yc * r_m[7].gy) >>> 30;
        r_t[4] <= (r_zc * r_m[7].ez) >>> 30; r_t[5] <= (r_yc * r_m[7].gz) >>> 30;
        r_en9 <= r_en;
        // s9
        if (r_on[8]) begin
            r_ox <= sat32(96'(r_fx[8]) + 96'(r_t[0]) + 96'(r_t[1]));
            r_oy <= sat32(96'(r_fy[8]) + 96'(r_t[2]) + 96'(r_t[3]));
            r_oz <= sat32(96'(r_fz[8]) + 96'(r_t[4]) + 96'(r_t[5]));
            r_oe <= r_en9;
        end else begin
            r_ox <= r_fx[8]; r_oy <= r_fy[8]; r_oz <= r_fz[8]; r_oe <= '0;
        end
        r_olast <= r_last[8];
    end

    assign o_valid = r_v[NS-1];
    assign o_data  = {r_olast, r_oe, r_oz, r_oy, r_ox};
endmodule

// ===== sv/rotational_anisotropy_field.sv =====
// rotational anisotropy field, sixth order odd form
// s_axis: one word per item; tdata packs action, material, spin xyz, field xyz,
// axis xyz; tuser carries last_atom. action 0 computes, 1..3 load tables.
// load words write the material table and produce no output word.
// m_axis: one word per compute item; tdata is field_out xyz and energy,
// tuser is last_out.
// i_cfg_we/i_cfg_wdata set the enable bit; write it only while idle.
// throughput: one word per cycle while s_axis_tready is high, set by the fully pipelined datapath.
// path: a result word goes from its accepted input word through the
// table read with input register, ten datapath stages, then the output fifo.
// the datapath never stalls; s_axis_tready drops once words in flight plus
// words held in the 16-entry output fifo reach 15, so a stalled receiver
// backs up the input and no word is dropped. with the receiver always ready
// the input never stalls.
// reset (synchronous, active low) clears enable, table valid bits and all
// pipeline valids; tables read as zero until loaded.
module rotational_anisotropy_field import raf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // action, material, spin x/y/z, field_in x/y/z, axis x/y/z
    input  logic [IN_TW-1:0]  s_axis_tdata,
    // last_atom
    input  logic              s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // field_out x/y/z, energy
    output logic [OUT_TW-1:0] m_axis_tdata,
    // last_out
    output logic              m_axis_tuser
);
    logic r_en;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_en <= 1'b0;
        else if (i_cfg_we) r_en <= i_cfg_wdata;
    end

    // pipeline runs freely; a credit count keeps outputs within the fifo
    localparam int FD = 16;
    localparam int FA = $clog2(FD);
    logic [OUT_TW:0] r_fifo [FD];
    logic [FA-1:0] r_wp, r_rp;
    logic [FA:0] r_cnt, r_inflight;

    logic [1:0] act;
    logic acc, cmp, pv, pop;
    logic [OUT_TW:0] pd;
    t_mat mat;
    logic r_cmp, r_last;
    logic [191:0] r_sf;

    assign act = s_axis_tdata[1:0];
    assign s_axis_tready = (32'(r_cnt) + 32'(r_inflight)) < FD - 1;
    assign acc = s_axis_tvalid & s_axis_tready;
    assign cmp = acc & (act == ACT_COMPUTE);

    raf_table u_tab (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_we(acc), .i_act(act),
        .i_wmat(s_axis_tdata[5:2]), .i_a0(s_axis_tdata[229:198]),
        .i_a1(s_axis_tdata[261:230]), .i_a2(s_axis_tdata[293:262]),
        .i_rmat(s_axis_tdata[5:2]), .o_mat(mat)
    );

    // spin and field ride along with the table read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cmp <= 1'b0;
        else          r_cmp <= cmp;
    end

    always_ff @(posedge i_clk) begin
        r_sf   <= s_axis_tdata[197:6];
        r_last <= s_axis_tuser;
    end

    raf_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(r_en), .i_valid(r_cmp),
        .i_act_on(1'b1), .i_mat(mat),
        .i_sx(r_sf[31:0]), .i_sy(r_sf[63:32]),
        .i_sz(r_sf[95:64]), .i_fx(r_sf[127:96]),
        .i_fy(r_sf[159:128]), .i_fz(r_sf[191:160]),
        .i_last(r_last), .o_valid(pv), .o_data(pd)
    );

    assign pop = m_axis_tvalid & m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; r_inflight <= '0;
        end else begin
            if (pv)  r_wp <= r_wp + 1'b1;
            if (pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (FA+1)'(pv) - (FA+1)'(pop);
            r_inflight <= r_inflight + (FA+1)'(cmp) - (FA+1)'(pv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pv) r_fifo[r_wp] <= pd;
    end

    assign m_axis_tvalid = r_cnt != '0;
    assign m_axis_tdata  = r_fifo[r_rp][OUT_TW-1:0];
    assign m_axis_tuser  = r_fifo[r_rp][OUT_TW];
endmodule

// ===== sv/raf_checker.sv =====
module raf_checker import raf_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [OUT_TW-1:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
    // a fresh output word comes from a word accepted a fixed latency earlier
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 12))
        else $error("output word without input");
endmodule

bind rotational_anisotropy_field raf_checker u_chk (.*);

// ===== dv/tb_rotational_anisotropy_field.sv =====
`timescale 1ns / 1ps

module tb_rotational_anisotropy_field;
    import raf_pkg::*;

    typedef struct {
        logic [1:0] action;
        logic [3:0] material;
        t_s32       sx, sy, sz, fx, fy, fz, a0, a1, a2;
        logic       last;
    } t_atom_word;

    typedef struct {
        t_s32 fx, fy, fz, energy;
        logic last;
    } t_field_word;

    typedef struct {
        t_atom_word w;
        logic       has_exp;
        t_s32       efx, efy, efz, eeng;
    } t_dir_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_wdata;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [IN_TW-1:0]   s_axis_tdata;
    logic               s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [OUT_TW-1:0]  m_axis_tdata;
    logic               m_axis_tuser;

    rotational_anisotropy_field u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    localparam t_s32 ONE_Q30 = 32'sh40000000;
    localparam t_s32 MAX32   = 32'sh7fffffff;
    localparam t_s32 MIN32   = 32'sh80000000;

    // predictor copy of tables and enable bit
    t_s32 easy_x[16], easy_y[16], easy_z[16];
    t_s32 sec_x[16], sec_y[16], sec_z[16], k_tab[16];
    logic en_bit;

    t_field_word field_q[$];
    int          errors;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint fshr(longint x, int n);
        return x >>> n;
    endfunction

    function automatic longint clip32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint mulsh(longint a, longint b, int n);
        return clip32(fshr(a * b, n));
    endfunction

    function automatic longint proj(t_s32 sx, t_s32 sy, t_s32 sz,
                                    t_s32 ax, t_s32 ay, t_s32 az);
        return clip32(fshr(longint'(sx) * ax, 30) + fshr(longint'(sy) * ay, 30)
                      + fshr(longint'(sz) * az, 30));
    endfunction

    // polynomials can exceed 64 bits only in theory; saturated inputs keep them small
    function automatic longint poly_q16(longint p);
        return clip32(fshr(p, 14));
    endfunction

    // updates tables for loads; returns 1 with the expected field word for computes
    function automatic bit field_update(t_atom_word w, output t_field_word r);
        longint fx, fy, fz, eng, ex, ey, ez, gx, gy, gz, k;
        longint s_z, s_y, z2, y2, y2z2, z4, y4, py, pz, pe, u, yc, zc, v, sysz;
        r = '{0, 0, 0, 0, 0};
        case (w.action)
            ACT_LOAD_EA: begin
                easy_x[w.material] = w.a0; easy_y[w.material] = w.a1;
                easy_z[w.material] = w.a2;
                return 0;
            end
            ACT_LOAD_SA: begin
                sec_x[w.material] = w.a0; sec_y[w.material] = w.a1;
                sec_z[w.material] = w.a2;
                return 0;
            end
            ACT_LOAD_K: begin
                k_tab[w.material] = w.a0;
                return 0;
            end
            default: ;
        endcase
        fx = w.fx; fy = w.fy; fz = w.fz; eng = 0;
        if (en_bit) begin
            ex = easy_x[w.material]; ey = easy_y[w.material]; ez = easy_z[w.material];
            gx = sec_x[w.material]; gy = sec_y[w.material]; gz = sec_z[w.material];
            k = k_tab[w.material];
            s_z = proj(w.sx, w.sy, w.sz, ex, ey, ez);
            s_y = proj(w.sx, w.sy, w.sz, gx, gy, gz);
            z2 = mulsh(s_z, s_z, 30);
            y2 = mulsh(s_y, s_y, 30);
            y2z2 = mulsh(y2, z2, 30);
            z4 = fshr(z2 * z2, 30);
            y4 = fshr(y2 * y2, 30);
            py = 16 * y4 + 12 * y2z2 + z4 - 2 * (6 * y2 + z2) + 5 * longint'(ONE_Q30);
            pz = 16 * y4 + 60 * y2z2 + 25 * z4 - 10 * (2 * y2 + 3 * z2)
                 + 5 * longint'(ONE_Q30);
            pe = 16 * y4 + 20 * y2z2 + 5 * z4 - 10 * (2 * y2 + z2)
                 + 5 * longint'(ONE_Q30);
            u = mulsh(s_z, poly_q16(py), 30);
            u = clip32(5 * u);
            yc = mulsh(k, u, 16);
            u = mulsh(s_y, poly_q16(pz), 30);
            zc = mulsh(k, u, 16);
            fx = clip32(fx + fshr(zc * ex, 30) + fshr(yc * gx, 30));
            fy = clip32(fy + fshr(zc * ey, 30) + fshr(yc * gy, 30));
            fz = clip32(fz + fshr(zc * ez, 30) + fshr(yc * gz, 30));
            sysz = mulsh(s_y, s_z, 30);
            v = mulsh(sysz, poly_q16(pe), 30);
            eng = clip32(-fshr(k * v, 16));
        end
        r.fx = fx[31:0]; r.fy = fy[31:0]; r.fz = fz[31:0];
        r.energy = eng[31:0];
        r.last = w.last;
        return 1;
    endfunction

    task automatic send_word(t_atom_word w);
        t_field_word r;
        s_axis_tdata  <= {{(IN_TW-IN_W){1'b0}}, w.a2, w.a1, w.a0, w.fz, w.fy, w.fx,
                          w.sz, w.sy, w.sx, w.material, w.action};
        s_axis_tuser  <= w.last;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (field_update(w, r)) field_q.push_back(r);
        @(negedge i_clk);
    endtask

    // rows with a typed expectation are checked against it instead of the predictor
    task automatic run_row(t_dir_row row);
        send_word(row.w);
        if (row.has_exp)
            field_q[field_q.size()-1] = '{row.efx, row.efy, row.efz, row.eeng, row.w.last};
    endtask

    task automatic go_idle();
        s_axis_tvalid <= 1'b0;
        while (field_q.size() != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    task automatic set_enable(logic v);
        go_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        en_bit       = v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic t_s32 rnd_q30();
        case ($urandom_range(0, 5))
            0:       return t_s32'($urandom());
            1:       return $urandom_range(0, 1) ? MAX32 : MIN32;
            2:       return t_s32'($urandom_range(0, 32'h7fffffff)) >>> 1;
            default: return t_s32'($urandom_range(0, 32'h80000000)) - ONE_Q30;
        endcase
    endfunction

    function automatic t_s32 rnd_field();
        return $urandom_range(0, 7) == 0 ? ($urandom_range(0, 1) ? MAX32 : MIN32)
                                         : t_s32'($urandom());
    endfunction

    function automatic t_atom_word rnd_word(logic [1:0] act);
        t_atom_word w;
        w.action = act;
        w.material = 4'($urandom_range(0, 15));
        w.sx = rnd_q30(); w.sy = rnd_q30(); w.sz = rnd_q30();
        w.fx = rnd_field(); w.fy = rnd_field(); w.fz = rnd_field();
        w.a0 = (act == ACT_LOAD_K) ? rnd_field() : rnd_q30();
        w.a1 = rnd_q30(); w.a2 = rnd_q30();
        w.last = 1'($urandom_range(0, 1));
        return w;
    endfunction

    // receiver: stall pattern changes with its own random mode
    initial begin
        int mode;
        m_axis_tready = 1'b0;
        mode = 0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
            case (mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                2:       m_axis_tready <= ($urandom_range(0, 7) == 0);
                default: m_axis_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_field_word e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (field_q.size() == 0) begin
                $error("unexpected output word %h", m_axis_tdata);
                errors++;
            end else begin
                e = field_q.pop_front();
                if (m_axis_tdata[31:0] !== e.fx) begin
                    $error("field_out_x exp %h got %h", e.fx, m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[63:32] !== e.fy) begin
                    $error("field_out_y exp %h got %h", e.fy, m_axis_tdata[63:32]);
                    errors++;
                end
                if (m_axis_tdata[95:64] !== e.fz) begin
                    $error("field_out_z exp %h got %h", e.fz, m_axis_tdata[95:64]);
                    errors++;
                end
                if (m_axis_tdata[127:96] !== e.energy) begin
                    $error("energy exp %h got %h", e.energy, m_axis_tdata[127:96]);
                    errors++;
                end
                if (m_axis_tuser !== e.last) begin
                    $error("last_out exp %b got %b", e.last, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("rotational_anisotropy_field regression: fail");
        $finish;
    end

    initial begin
        t_dir_row dir_tab[$];
        t_atom_word w;
        int burst;
        i_clk = 1'b0;
        errors = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        en_bit = 1'b0;
        for (int i = 0; i < 16; i++) begin
            easy_x[i] = 0; easy_y[i] = 0; easy_z[i] = 0;
            sec_x[i] = 0; sec_y[i] = 0; sec_z[i] = 0; k_tab[i] = 0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // disabled: pass through, energy zero; then table loads for materials 0 and 15
        dir_tab.push_back('{'{ACT_COMPUTE, 4'd0, MAX32, MIN32, ONE_Q30, MAX32, MIN32,
                              32'sd0, 0, 0, 0, 1'b1}, 1'b1, MAX32, MIN32, 32'sd0, 32'sd0});
        dir_tab.push_back('{'{ACT_COMPUTE, 4'd15, MIN32, MAX32, 0, MIN32, MAX32,
                              32'sh12345678, 0, 0, 0, 1'b0}, 1'b1, MIN32, MAX32,
                             32'sh12345678, 32'sd0});
        dir_tab.push_back('{'{ACT_LOAD_EA, 4'd0, 0, 0, 0, 0, 0, 0, 0, 0, ONE_Q30, 1'b0},
                            1'b0, 0, 0, 0, 0});
        dir_tab.push_back('{'{ACT_LOAD_SA, 4'd0, 0, 0, 0, 0, 0, 0, 0, ONE_Q30, 0, 1'b0},
                            1'b0, 0, 0, 0, 0});
        dir_tab.push_back('{'{ACT_LOAD_K, 4'd0, 0, 0, 0, 0, 0, 0, 32'sh10000, 0, 0, 1'b1},
                            1'b0, 0, 0, 0, 0});
        dir_tab.push_back('{'{ACT_LOAD_EA, 4'd15, 0, 0, 0, 0, 0, 0, MAX32, MIN32, MAX32,
                              1'b0}, 1'b0, 0, 0, 0, 0});
        dir_tab.push_back('{'{ACT_LOAD_SA, 4'd15, 0, 0, 0, 0, 0, 0, MIN32, MAX32, MIN32,
                              1'b0}, 1'b0, 0, 0, 0, 0});
        dir_tab.push_back('{'{ACT_LOAD_K, 4'd15, 0, 0, 0, 0, 0, 0, MAX32, 0, 0, 1'b0},
                            1'b0, 0, 0, 0, 0});
        foreach (dir_tab[i]) run_row(dir_tab[i]);

        set_enable(1'b1);
        // enabled: unit axes, oversized spins, saturating strength, untouched material
        dir_tab.delete();
        dir_tab.push_back('{'{ACT_COMPUTE, 4'd0, 0, ONE_Q30, 0, 0, 0, 0, 0, 0, 0, 1'b0},
                            1'b0, 0, 0, 0, 0});
        dir_tab.push_back('{'{ACT_COMPUTE, 4'd0, 0, 32'sh2d413ccd, 32'sh2d413ccd,
                              32'sh10000, 0, MIN32, 0, 0, 0, 1'b1}, 1'b0, 0, 0, 0, 0});
        dir_tab.push_back('{'{ACT_COMPUTE, 4'd0, MAX32, MAX32, MAX32, MAX32, MAX32, MAX32,
                              0, 0, 0, 1'b0}, 1'b0, 0, 0, 0, 0});
        dir_tab.push_back('{'{ACT_COMPUTE, 4'd15, MAX32, MIN32, MAX32, MIN32, MIN32, MIN32,
                              0, 0, 0, 1'b1}, 1'b0, 0, 0, 0, 0});
        dir_tab.push_back('{'{ACT_COMPUTE, 4'd15, MIN32, MIN32, MIN32, 0, 0, 0, 0, 0, 0,
                              1'b0}, 1'b0, 0, 0, 0, 0});
        dir_tab.push_back('{'{ACT_COMPUTE, 4'd7, ONE_Q30, ONE_Q30, ONE_Q30, 32'sh55, 0, 1,
                              0, 0, 0, 1'b1}, 1'b1, 32'sh55, 0, 1, 0});
        foreach (dir_tab[i]) run_row(dir_tab[i]);

        set_enable(1'b0);
        for (int i = 0; i < 16; i++) send_word(rnd_word(ACT_COMPUTE));
        set_enable(1'b1);

        // random: mostly computes over random materials, some table reloads, enable off for part of the run
        for (int n = 0; n < 1300; ) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < 1300; b++, n++) begin
                case ($urandom_range(0, 9))
                    0:       w = rnd_word(ACT_LOAD_EA);
                    1:       w = rnd_word(ACT_LOAD_SA);
                    2:       w = rnd_word(ACT_LOAD_K);
                    default: w = rnd_word(ACT_COMPUTE);
                endcase
                send_word(w);
                if (n == 650) set_enable(1'b0);
                if (n == 800) set_enable(1'b1);
            end
            if ($urandom_range(0, 3) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end

        go_idle();
        if (errors == 0) begin
            $display("rotational_anisotropy_field regression: pass");
        end else begin
            $display("rotational_anisotropy_field regression: fail");
        end
        $finish;
    end

endmodule
